// ----- design/ttb_pkg.sv -----
// Shared types and codes for the trace timestamp back-patcher.
package ttb_pkg;

    // Input action codes
    localparam logic ACT_TOKEN = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Token kinds
    localparam logic [3:0] TT_MISC      = 4'd0;
    localparam logic [3:0] TT_TIMESTAMP = 4'd1;

    // Miscellaneous sub-kinds
    localparam logic [3:0] MK_TIME_RESET = 4'd1;
    localparam logic [3:0] MK_ADVANCE_A  = 4'd2;
    localparam logic [3:0] MK_ADVANCE_B  = 4'd4;
    localparam logic [3:0] MK_ADVANCE_C  = 4'd5;

    // Time granule: one delta tick is four time units (a shift of two)
    localparam int          TICK_SHIFT = 2;
    localparam logic [63:0] TIME_STEP  = 64'd4;

    typedef enum logic [1:0] {
        ST_TIMED      = 2'd0,
        ST_SKIPPED    = 2'd1,
        ST_UNRESOLVED = 2'd2,
        ST_DROPPED    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TS,
        S_REL,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic        action;
        logic [3:0]  token_type;
        logic [3:0]  misc_kind;
        logic [15:0] delta_ticks;
        logic [63:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic [63:0] token_time;
        t_status     status;
        logic        last;
    } t_out_item;

    // Controls from the sequencer to the hold chain
    typedef struct packed {
        logic wr_en;
        logic shift;
    } t_chain_ctl;

endpackage

// ----- design/trace_timestamp_backpatcher.sv -----
// Top level of the trace timestamp back-patcher: sequencer, time registers, hold chain.
//
//  channel | valid       | ready       | payload     | moves
//  --------+-------------+-------------+-------------+------------------------------
//  input   | i_in_valid  | o_in_ready  | i_in_data   | one trace token or a flush
//  output  | o_out_valid | i_out_ready | o_out_data  | one released token result
//
//  Flow: an ordinary token is one transfer per cycle while results are taken.
//  A timestamp is accepted, the time is rewound in S_TS, then S_REL releases
//  each held token in turn while the output is free, and the timestamp result
//  last. A flush releases each held token as unresolved from S_FLUSH. The
//  release path adds the head cell's delta to the running time in a 64-bit adder.
//  Reset is synchronous, active low; it clears the time registers, the window,
//  the held count and the output valid flag. The hold cells keep stale data.
//  A stalled output holds its result; the input is taken only when the output
//  register is empty or being drained in the same cycle.
module trace_timestamp_backpatcher #(
    parameter int HOLD_DEPTH = 32,
    parameter int DELTA_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ttb_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ttb_pkg::t_out_item  o_out_data
);

    // Held count reaches HOLD_DEPTH itself
    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);

    ttb_pkg::t_state     r_state, n_state;
    logic [63:0]         r_base, n_base;
    logic [63:0]         r_rel, n_rel;
    logic                r_win, n_win;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [63:0]         r_diff, n_diff;      // timestamp minus base, before rounding
    logic                r_first, n_first;    // next release is the window opener
    logic                r_out_valid, n_out_valid;
    ttb_pkg::t_out_item  r_out_data, n_out_data;

    ttb_pkg::t_chain_ctl   w_ctl;
    logic [DELTA_BITS-1:0] w_head_delta;
    logic [31:0]           w_delta_ext;
    logic [DELTA_BITS-1:0] w_delta;
    logic [63:0]           w_in_adv;
    logic [63:0]           w_head_adv;
    logic                  w_out_free;
    logic                  w_accept;
    logic                  w_adv_kind;
    logic                  w_reset_kind;
    logic                  w_full;
    logic [63:0]           w_rel_time;

    // Only the low DELTA_BITS of the delta field count
    assign w_delta_ext = 32'(i_in_data.delta_ticks);
    assign w_delta     = w_delta_ext[DELTA_BITS-1:0];
    assign w_in_adv    = 64'(w_delta) << ttb_pkg::TICK_SHIFT;
    assign w_head_adv  = 64'(w_head_delta) << ttb_pkg::TICK_SHIFT;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ttb_pkg::S_IDLE) && w_out_free;
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_reset_kind = (i_in_data.token_type == ttb_pkg::TT_MISC)
                       && (i_in_data.misc_kind == ttb_pkg::MK_TIME_RESET);
    assign w_adv_kind   = (i_in_data.token_type == ttb_pkg::TT_MISC)
                       && ((i_in_data.misc_kind == ttb_pkg::MK_ADVANCE_A)
                        || (i_in_data.misc_kind == ttb_pkg::MK_ADVANCE_B)
                        || (i_in_data.misc_kind == ttb_pkg::MK_ADVANCE_C));
    assign w_full       = (r_cnt == CNT_W'(HOLD_DEPTH));

    // Release time: the opener goes out at the rewound time, later slots add their delta
    assign w_rel_time = r_first ? r_rel : (r_rel + w_head_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttb_pkg::S_IDLE;
            r_base      <= '0;
            r_rel       <= '0;
            r_win       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_rel       <= n_rel;
            r_win       <= n_win;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff     <= n_diff;
        r_first    <= n_first;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_rel       = r_rel;
        n_win       = r_win;
        n_cnt       = r_cnt;
        n_diff      = r_diff;
        n_first     = r_first;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_ctl       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ttb_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.action == ttb_pkg::ACT_FLUSH) begin
                        // Back to reset state; the count drives the unresolved burst
                        n_base = '0;
                        n_rel  = '0;
                        n_win  = 1'b0;
                        if (r_cnt != '0) begin
                            n_state = ttb_pkg::S_FLUSH;
                        end
                    end else if (i_in_data.token_type == ttb_pkg::TT_TIMESTAMP) begin
                        if (!r_win && (r_base != '0)) begin
                            n_out_valid           = 1'b1;
                            n_out_data.token_time = '0;
                            n_out_data.status     = ttb_pkg::ST_SKIPPED;
                            n_out_data.last       = 1'b1;
                        end else begin
                            // First timestamp fixes base so that ts - base equals rel
                            if (r_base == '0) begin
                                n_base = i_in_data.timestamp - r_rel;
                                n_diff = r_rel;
                            end else begin
                                n_diff = i_in_data.timestamp - r_base;
                            end
                            n_state = ttb_pkg::S_TS;
                        end
                    end else if (r_win) begin
                        if (w_full) begin
                            n_out_valid           = 1'b1;
                            n_out_data.token_time = '0;
                            n_out_data.status     = ttb_pkg::ST_DROPPED;
                            n_out_data.last       = 1'b1;
                        end else begin
                            w_ctl.wr_en = 1'b1;
                            n_cnt       = r_cnt + CNT_W'(1);
                            if (w_adv_kind) begin
                                n_rel = r_rel + w_in_adv;
                            end
                        end
                    end else begin
                        n_rel = r_rel + w_in_adv;
                        if (w_reset_kind) begin
                            // Window opener lands in slot 0 (count is zero here)
                            w_ctl.wr_en = 1'b1;
                            n_win       = 1'b1;
                            n_cnt       = CNT_W'(1);
                        end else begin
                            n_out_valid           = 1'b1;
                            n_out_data.token_time = r_rel + w_in_adv;
                            n_out_data.status     = ttb_pkg::ST_TIMED;
                            n_out_data.last       = 1'b1;
                        end
                    end
                end
            end

            ttb_pkg::S_TS: begin
                // Round down to the tick granule, then step back one granule
                n_rel   = {r_diff[63:2], 2'b00} - ttb_pkg::TIME_STEP;
                n_first = 1'b1;
                n_state = ttb_pkg::S_REL;
            end

            ttb_pkg::S_REL: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_cnt != '0) begin
                        n_rel                 = w_rel_time;
                        n_out_data.token_time = w_rel_time;
                        n_out_data.status     = ttb_pkg::ST_TIMED;
                        n_out_data.last       = 1'b0;
                        w_ctl.shift           = 1'b1;
                        n_first               = 1'b0;
                        n_cnt                 = r_cnt - CNT_W'(1);
                    end else begin
                        // The timestamp itself closes the burst
                        n_out_data.token_time = r_rel;
                        n_out_data.status     = ttb_pkg::ST_TIMED;
                        n_out_data.last       = 1'b1;
                        n_win                 = 1'b0;
                        n_state               = ttb_pkg::S_IDLE;
                    end
                end
            end

            ttb_pkg::S_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_data.token_time = '0;
                    n_out_data.status     = ttb_pkg::ST_UNRESOLVED;
                    n_out_data.last       = (r_cnt == CNT_W'(1));
                    n_cnt                 = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ttb_pkg::S_IDLE;
                    end
                end
            end

            default: begin
                n_state = ttb_pkg::S_IDLE;
            end
        endcase
    end

    ttb_hold_chain #(
        .HOLD_DEPTH (HOLD_DEPTH),
        .DELTA_BITS (DELTA_BITS),
        .CNT_W      (CNT_W)
    ) u_chain (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_wr_idx     (r_cnt),
        .i_wr_delta   (w_delta),
        .o_head_delta (w_head_delta)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- design/ttb_cell.sv -----
// One hold cell: a delta register that loads locally or takes its right neighbor's value.
module ttb_cell #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic [W-1:0] i_load_data,
    input  logic         i_shift,
    input  logic [W-1:0] i_shift_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_shift_data;
        end
    end

    assign o_data = r_data;

endmodule

// ----- design/ttb_hold_chain.sv -----
// Row of hold cells: indexed write of held deltas, shift toward the head on release.
module ttb_hold_chain #(
    parameter int HOLD_DEPTH = 32,
    parameter int DELTA_BITS = 16,
    parameter int CNT_W      = 6
) (
    input  logic                  i_clk,
    input  ttb_pkg::t_chain_ctl   i_ctl,
    input  logic [CNT_W-1:0]      i_wr_idx,
    input  logic [DELTA_BITS-1:0] i_wr_delta,
    output logic [DELTA_BITS-1:0] o_head_delta
);

    logic [DELTA_BITS-1:0] w_data [HOLD_DEPTH];

    for (genvar g = 0; g < HOLD_DEPTH; g++) begin : g_cell
        logic [DELTA_BITS-1:0] w_next;
        logic                  w_load;

        if (g == HOLD_DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_data[g+1];
        end

        assign w_load = i_ctl.wr_en && (i_wr_idx == CNT_W'(g));

        ttb_cell #(
            .W(DELTA_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_load       (w_load),
            .i_load_data  (i_wr_delta),
            .i_shift      (i_ctl.shift),
            .i_shift_data (w_next),
            .o_data       (w_data[g])
        );
    end

    assign o_head_delta = w_data[0];

endmodule

// ----- design/ttb_checker.sv -----
// Port-level checks for the back-patcher, bound to the top level.
module ttb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input ttb_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ttb_pkg::t_out_item o_out_data
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // No new token is taken while a result is stuck
    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    // Skipped and dropped results stand alone with zero time
    a_single_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ttb_pkg::ST_SKIPPED
                     || o_out_data.status == ttb_pkg::ST_DROPPED)
        |-> o_out_data.last && (o_out_data.token_time == '0))
        else $error("skip or drop result malformed");

    // Unresolved tokens carry no time
    a_unresolved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ttb_pkg::ST_UNRESOLVED)
        |-> (o_out_data.token_time == '0))
        else $error("unresolved result has a time");

endmodule

bind trace_timestamp_backpatcher ttb_checker u_ttb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
